FILE: hdl/gmpd_pkg.sv
// ----------------------------------------------------------------------------
// gmpd_pkg
// shared sizes, codes and constants of the grid path distance unit
// ----------------------------------------------------------------------------
`default_nettype none

package gmpd_pkg;

  // grid edge length in cells, 2 to 8
  localparam int GRID_SIZE = 8;

  // coordinate and cell widths
  localparam int COORD_W = 3;
  localparam int ADDR_W  = 2 * COORD_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int CELL_W  = 5;
  localparam int CMD_W   = 2;

  // last row / column index inside the grid
  localparam logic [COORD_W-1:0] LAST_IDX = COORD_W'(GRID_SIZE - 1);
  localparam logic [COORD_W:0]   GRID_LIM = (COORD_W + 1)'(GRID_SIZE);

  // cell codes
  localparam logic [CELL_W-1:0] BLOCKED_CELL = {CELL_W{1'b1}};
  localparam logic [CELL_W-1:0] FREE_CELL    = {CELL_W{1'b0}};

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SOLVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

endpackage

`default_nettype wire

FILE: hdl/grid_monotone_path_distance_unit.sv
// ----------------------------------------------------------------------------
// grid_monotone_path_distance_unit
// right/down path distance grid with write, solve and read commands
// ----------------------------------------------------------------------------
// The unit keeps a GRID_SIZE by GRID_SIZE grid of 5-bit signed cells in one
// dual-read, single-write memory, addressed {row, col}. A cell holds -1 when
// blocked or unreachable, else the step count to the bottom-right corner.
// A write transaction marks one cell blocked (-1) or free (0);
// a write outside the grid is dropped. A read transaction returns the cell
// through the memory read register and an output register (-1 outside the
// grid). A solve transaction sweeps the grid from the bottom-right corner,
// row by row and right to left, one cell per cycle. Each cell is read
// together with the cell below it; the cell to its right was finished in
// the cycle before and is forwarded from a register. Command 3 is taken
// and does nothing. After reset every cell reads as free through per-entry
// valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_monotone_path_distance_unit (
  input  wire                                  clk,
  input  wire                                  rst,
  // command channel
  input  wire                                  cmd_valid,
  output logic                                 cmd_stall,
  input  wire  [gmpd_pkg::CMD_W-1:0]           command,
  input  wire  [gmpd_pkg::COORD_W-1:0]         col,
  input  wire  [gmpd_pkg::COORD_W-1:0]         row,
  input  wire                                  blocked,
  // response channel
  output logic                                 rsp_valid,
  input  wire                                  rsp_stall,
  output logic signed [gmpd_pkg::CELL_W-1:0]   cell_value
);

  localparam int CW = gmpd_pkg::CELL_W;
  localparam int XW = gmpd_pkg::COORD_W;
  localparam int AW = gmpd_pkg::ADDR_W;

  // sequencer state codes
  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SOLVE = 1'b1;

  logic state;

  // grid storage and its reset-valid bits
  logic [CW-1:0]                grid_mem [gmpd_pkg::DEPTH];
  logic [gmpd_pkg::DEPTH-1:0]   vld;

  // sweep position (issue stage)
  logic [XW-1:0] sx;
  logic [XW-1:0] sy;

  // read ports, registered data
  logic [AW-1:0] rd_a_addr;
  logic [AW-1:0] rd_b_addr;
  logic [CW-1:0] rd_a_data;
  logic [CW-1:0] rd_b_data;
  logic          rd_a_vld;
  logic          rd_b_vld;

  // compute stage of the sweep
  logic          s1_valid;
  logic [AW-1:0] s1_addr;
  logic          s1_right_in;
  logic          s1_down_in;
  logic          s1_corner;
  logic [CW-1:0] right_val;

  // pending read command
  logic          rd_pending;
  logic          rd_in;

  // write port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] wr_data;

  logic          busy;
  logic          cmd_acc;
  logic          cmd_in_grid;
  logic          issue;

  logic [CW-1:0] cur_val;
  logic [CW-1:0] down;
  logic [CW-1:0] right_inc;
  logic [CW-1:0] down_inc;
  logic          right_ok;
  logic          down_ok;
  logic [CW-1:0] res;

  // ---------------------------------------------------------------- control
  // a read may only enter when the output register is free by the time the
  // memory data comes back
  assign busy      = (state == ST_SOLVE) || s1_valid || rd_pending;
  assign cmd_stall = busy || ((command == gmpd_pkg::CMD_READ) && rsp_valid && rsp_stall);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign issue     = (state == ST_SOLVE);

  assign cmd_in_grid = ({1'b0, col} < gmpd_pkg::GRID_LIM) &&
                       ({1'b0, row} < gmpd_pkg::GRID_LIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sx    <= gmpd_pkg::LAST_IDX;
      sy    <= gmpd_pkg::LAST_IDX;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_acc && (command == gmpd_pkg::CMD_SOLVE)) begin
            state <= ST_SOLVE;
            sx    <= gmpd_pkg::LAST_IDX;
            sy    <= gmpd_pkg::LAST_IDX;
          end
        end
        ST_SOLVE: begin
          // walk right to left, bottom row first
          if (sx == '0) begin
            sx <= gmpd_pkg::LAST_IDX;
            if (sy == '0) begin
              state <= ST_IDLE;
            end else begin
              sy <= sy - XW'(1);
            end
          end else begin
            sx <= sx - XW'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- memory
  // port a: the swept cell or the cell a read asks for; port b: cell below
  assign rd_a_addr = issue ? {sy, sx} : {row, col};
  assign rd_b_addr = {sy + XW'(1), sx};

  always_ff @(posedge clk) begin
    rd_a_data <= grid_mem[rd_a_addr];
    rd_b_data <= grid_mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
  end

  // an entry never written since reset reads as free
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_a_vld <= 1'b0;
      rd_b_vld <= 1'b0;
    end else begin
      rd_a_vld <= vld[rd_a_addr];
      rd_b_vld <= vld[rd_b_addr];
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr     <= {sy, sx};
    s1_right_in <= (sx != gmpd_pkg::LAST_IDX);
    s1_down_in  <= (sy != gmpd_pkg::LAST_IDX);
    s1_corner   <= (sx == gmpd_pkg::LAST_IDX) && (sy == gmpd_pkg::LAST_IDX);
  end

  assign cur_val   = rd_a_vld ? rd_a_data : gmpd_pkg::FREE_CELL;
  assign down      = rd_b_vld ? rd_b_data : gmpd_pkg::FREE_CELL;
  assign right_ok  = s1_right_in && (right_val != gmpd_pkg::BLOCKED_CELL);
  assign down_ok   = s1_down_in && (down != gmpd_pkg::BLOCKED_CELL);
  assign right_inc = right_val + CW'(1);
  assign down_inc  = down + CW'(1);

  // distances are never negative here, so an unsigned compare picks the min
  always_comb begin
    if (cur_val == gmpd_pkg::BLOCKED_CELL) begin
      res = gmpd_pkg::BLOCKED_CELL;
    end else if (s1_corner) begin
      res = gmpd_pkg::FREE_CELL;
    end else if (right_ok && down_ok) begin
      res = (down < right_val) ? down_inc : right_inc;
    end else if (right_ok) begin
      res = right_inc;
    end else if (down_ok) begin
      res = down_inc;
    end else begin
      res = gmpd_pkg::BLOCKED_CELL;
    end
  end

  // the result becomes the right neighbour of the next cell in the row
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      right_val <= res;
    end
  end

  // sweep write-back and command writes never overlap (busy interlock)
  always_comb begin
    if (s1_valid) begin
      wr_en   = 1'b1;
      wr_addr = s1_addr;
      wr_data = res;
    end else begin
      wr_en   = cmd_acc && (command == gmpd_pkg::CMD_WRITE) && cmd_in_grid;
      wr_addr = {row, col};
      wr_data = blocked ? gmpd_pkg::BLOCKED_CELL : gmpd_pkg::FREE_CELL;
    end
  end

  // ---------------------------------------------------------------- read path
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= cmd_acc && (command == gmpd_pkg::CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      rd_in <= cmd_in_grid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rd_pending) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending) begin
      cell_value <= rd_in ? $signed(cur_val) : $signed(gmpd_pkg::BLOCKED_CELL);
    end
  end

  // ---------------------------------------------------------------- checks
  a_rsp_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(rd_pending))
    else $error("response raised without a pending read");

  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && (command == gmpd_pkg::CMD_READ)) |=> (rd_pending && !s1_valid))
    else $error("accepted read did not reach the read stage");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && rd_pending))
    else $error("sweep write-back overlaps a read");

  a_solve_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SOLVE) |-> (cmd_stall && !rd_pending))
    else $error("command accepted during a sweep");

  a_sweep_len: assert property (@(posedge clk) disable iff (rst)
    $fell(s1_valid) |-> ($past(s1_addr) == '0))
    else $error("sweep ended away from the first cell");

endmodule

`default_nettype wire
